FILE: rtl/core/rpn_stack_evaluator_defines.svh
// ----------------------------------------------------------------------------
// RPN stack evaluator assertion macros
// Shorthand for clocked checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

// Same-cycle implication
`define RPN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared constants, enums and the command/status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int RAM_AW      = $clog2(STACK_DEPTH);
	localparam int DATA_W      = 64;
	localparam int HALF_W      = DATA_W / 2;
	localparam int CHAR_W      = 8;
	localparam int ERR_W       = 2;
	localparam int OUT_TDATA_W = ((DATA_W + ERR_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - ERR_W;
	localparam int DIV_STEPS   = DATA_W;
	localparam int CNT_W       = $clog2(DIV_STEPS);

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'd42;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'd47;
	localparam logic [CHAR_W-1:0] CH_BIAS  = 8'd48;

	// partial products of the low half of a 64x64 product
	localparam logic [1:0] MUL_LO_LO = 2'd0;
	localparam logic [1:0] MUL_LO_HI = 2'd1;
	localparam logic [1:0] MUL_HI_LO = 2'd2;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE  = 2'd0,
		ERR_UNDER = 2'd1,
		ERR_OVER  = 2'd2,
		ERR_DIV0  = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       rd;
		logic       ld;
		logic       mul_step;
		logic [1:0] mul_phase;
		logic       div_step;
		logic       commit;
		logic       push;
		logic       set_err;
		err_t       err;
		logic       emit;
		op_t        op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		err_t             err;
		logic             top_zero;
		logic             out_busy;
	} dp_status_t;

endpackage

FILE: rtl/core/rpn_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/rpn_ctrl.sv
// ----------------------------------------------------------------------------
// RPN controller
// Decodes each character word and sequences the datapath.
// ----------------------------------------------------------------------------
module rpn_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_valid,
	input  logic [rpn_pkg::CHAR_W-1:0] char_code,
	output logic                       s_ready,
	input  rpn_pkg::dp_status_t        status,
	output rpn_pkg::ctrl_cmd_t         cmd
);
	import rpn_pkg::*;

	state_t           state_q, state_d;
	op_t              op_q, op_dec;
	logic [CNT_W-1:0] cnt_q;
	logic             accept, is_op, op_ok;

	always_comb begin
		is_op  = 1'b1;
		op_dec = OP_ADD;
		case (char_code)
			CH_PLUS:  op_dec = OP_ADD;
			CH_MINUS: op_dec = OP_SUB;
			CH_STAR:  op_dec = OP_MUL;
			CH_SLASH: op_dec = OP_DIV;
			default:  is_op  = 1'b0;
		endcase
	end

	assign accept = s_valid && (state_q == ST_IDLE);
	// enough operands, and no zero divisor
	assign op_ok  = (status.level >= LVL_W'(2)) && !((op_dec == OP_DIV) && status.top_zero);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (char_code == CH_NUL)) begin
					state_d = ST_EMIT;
				end else if (accept && (status.err == ERR_NONE) && is_op && op_ok) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				case (op_q)
					OP_MUL:  state_d = ST_MUL;
					OP_DIV:  state_d = ST_DIV;
					default: state_d = ST_FIN;
				endcase
			end
			ST_MUL: begin
				if (cnt_q == CNT_W'(MUL_HI_LO)) begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:  state_d = ST_IDLE;
			ST_EMIT: begin
				if (!status.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.op        = op_q;
		cmd.err       = ERR_NONE;
		cmd.mul_phase = cnt_q[1:0];
		s_ready       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_ready = 1'b1;
				if (accept && (char_code != CH_NUL) && (char_code != CH_SPACE)
						&& (status.err == ERR_NONE)) begin
					if (is_op) begin
						if (status.level < LVL_W'(2)) begin
							cmd.set_err = 1'b1;
							cmd.err     = ERR_UNDER;
						end else if ((op_dec == OP_DIV) && status.top_zero) begin
							cmd.set_err = 1'b1;
							cmd.err     = ERR_DIV0;
						end else begin
							cmd.rd = 1'b1;
						end
					end else if (status.level >= LVL_W'(STACK_DEPTH)) begin
						cmd.set_err = 1'b1;
						cmd.err     = ERR_OVER;
					end else begin
						cmd.push = 1'b1;
					end
				end
			end
			ST_LOAD: cmd.ld       = 1'b1;
			ST_MUL:  cmd.mul_step = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_FIN:  cmd.commit   = 1'b1;
			ST_EMIT: cmd.emit     = !status.out_busy;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_ADD;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.rd) begin
				op_q <= op_dec;
			end
			if ((state_q == ST_MUL) || (state_q == ST_DIV)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

FILE: rtl/core/rpn_datapath.sv
// ----------------------------------------------------------------------------
// RPN datapath
// Top-of-stack register over a RAM of lower entries, a shared 32x32
// multiplier, a radix-2 restoring divider and the result word register.
// ----------------------------------------------------------------------------
module rpn_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rpn_pkg::CHAR_W-1:0] char_code,
	input  rpn_pkg::ctrl_cmd_t         cmd,
	input  logic                       out_ready,
	output rpn_pkg::dp_status_t        status,
	output logic [rpn_pkg::DATA_W-1:0] out_value,
	output logic [rpn_pkg::ERR_W-1:0]  out_error,
	output logic                       out_valid
);
	import rpn_pkg::*;

	logic [DATA_W-1:0]   top_q, a_q, b_q, acc_q, prod_q, rem_q, out_value_q;
	logic [LVL_W-1:0]    level_q, lvl_m1, lvl_m2;
	err_t                err_q, out_err_q;
	logic                neg_q, out_valid_q;
	logic [DATA_W-1:0]   rdata, push_val, result, rem_sh, rem_n;
	logic [HALF_W-1:0]   mul_a, mul_b;
	logic [DATA_W-1:0]   mul_p;
	logic                rem_ge;

	assign lvl_m1 = level_q - LVL_W'(1);
	assign lvl_m2 = level_q - LVL_W'(2);

	// entries below the top; the top itself lives in top_q
	rpn_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (cmd.push && (level_q != '0)),
		.waddr(lvl_m1[RAM_AW-1:0]),
		.wdata(top_q),
		.re   (cmd.rd),
		.raddr(lvl_m2[RAM_AW-1:0]),
		.rdata(rdata)
	);

	assign push_val = DATA_W'(char_code) - DATA_W'(CH_BIAS);

	always_comb begin
		case (cmd.mul_phase)
			MUL_LO_HI: begin
				mul_a = a_q[HALF_W-1:0];
				mul_b = b_q[DATA_W-1:HALF_W];
			end
			MUL_HI_LO: begin
				mul_a = a_q[DATA_W-1:HALF_W];
				mul_b = b_q[HALF_W-1:0];
			end
			default: begin
				mul_a = a_q[HALF_W-1:0];
				mul_b = b_q[HALF_W-1:0];
			end
		endcase
	end

	assign mul_p = DATA_W'(mul_a) * DATA_W'(mul_b);

	assign rem_sh = {rem_q[DATA_W-2:0], a_q[DATA_W-1]};
	assign rem_ge = (rem_sh >= b_q);
	assign rem_n  = rem_ge ? (rem_sh - b_q) : rem_sh;

	always_comb begin
		case (cmd.op)
			OP_ADD:  result = a_q + b_q;
			OP_SUB:  result = a_q - b_q;
			OP_MUL:  result = acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
			OP_DIV:  result = neg_q ? (DATA_W'(0) - a_q) : a_q;
			default: result = a_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			if ((cmd.op == OP_DIV) && rdata[DATA_W-1]) begin
				a_q <= DATA_W'(0) - rdata;
			end else begin
				a_q <= rdata;
			end
			if ((cmd.op == OP_DIV) && top_q[DATA_W-1]) begin
				b_q <= DATA_W'(0) - top_q;
			end else begin
				b_q <= top_q;
			end
			neg_q <= rdata[DATA_W-1] ^ top_q[DATA_W-1];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_n;
			a_q   <= {a_q[DATA_W-2:0], rem_ge};
		end
		if (cmd.mul_step) begin
			prod_q <= mul_p;
			if (cmd.mul_phase == MUL_LO_HI) begin
				acc_q <= prod_q;
			end else if (cmd.mul_phase == MUL_HI_LO) begin
				acc_q <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
			end
		end
		if (cmd.commit) begin
			top_q <= result;
		end else if (cmd.push) begin
			top_q <= push_val;
		end
		if (cmd.emit) begin
			out_value_q <= ((err_q == ERR_NONE) && (level_q != '0)) ? top_q : '0;
			if (err_q != ERR_NONE) begin
				out_err_q <= err_q;
			end else if (level_q == '0) begin
				out_err_q <= ERR_UNDER;
			end else begin
				out_err_q <= ERR_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				level_q <= '0;
				err_q   <= ERR_NONE;
			end else if (cmd.commit) begin
				level_q <= lvl_m1;
			end else if (cmd.push) begin
				level_q <= level_q + LVL_W'(1);
			end else if (cmd.set_err && (err_q == ERR_NONE)) begin
				err_q <= cmd.err;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.level    = level_q;
	assign status.err      = err_q;
	assign status.top_zero = (top_q == '0);
	assign status.out_busy = out_valid_q && !out_ready;

	assign out_value = out_value_q;
	assign out_error = out_err_q;
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// RPN stack evaluator
// Postfix calculator on a stack of signed 64-bit values, one character a word.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one character code per word. Space is skipped,
// + - * / pop two values and push the result, NUL closes the expression,
// any other code pushes its value minus 48.
// Output channel (m_axis): one word per NUL, carrying the top of the stack
// (or 0) and an error code: 0 ok, 1 underflow, 2 overflow, 3 divide by zero.
// The first error sticks; later characters are dropped until the NUL.
// Words are taken only in the idle state. Push, space, NUL and error cases
// finish there (NUL then passes the emit state); + and - pass the load and
// finish states; * also steps the shared 32x32 multiplier through its
// partial products; / steps the radix-2 divider, one quotient bit per cycle.
// The emit state registers the result word once the output slot is free.
// Reset empties the stack and clears the error and the output valid flag; the
// stack RAM is not cleared, entries are only read once written.
// A stalled receiver holds the result word in the output register; the block
// keeps taking characters, and only a second NUL waits for the slot to free.
// ----------------------------------------------------------------------------
`include "rpn_stack_evaluator_defines.svh"

module rpn_stack_evaluator (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave side: [7:0] char_code
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [rpn_pkg::CHAR_W-1:0]      s_axis_tdata,
	// master side: [63:0] value, [65:64] error_code, [71:66] zero
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [rpn_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import rpn_pkg::*;

	ctrl_cmd_t         cmd;
	dp_status_t        status;
	logic [DATA_W-1:0] out_value;
	logic [ERR_W-1:0]  out_error;

	// sequencer: character decode, operator steps, result hand-off
	rpn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_axis_tvalid),
		.char_code(s_axis_tdata),
		.s_ready  (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// stack, arithmetic and output word register
	rpn_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_code(s_axis_tdata),
		.cmd      (cmd),
		.out_ready(m_axis_tready),
		.status   (status),
		.out_value(out_value),
		.out_error(out_error),
		.out_valid(m_axis_tvalid)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_error, out_value};

	// stack level never passes the depth
	`RPN_ASSERT_NOW(a_level_bound, 1'b1, status.level <= LVL_W'(STACK_DEPTH), "stack level beyond depth")
	// a result is loaded only into a free output slot
	`RPN_ASSERT_NOW(a_emit_free, cmd.emit, !status.out_busy, "result loaded over a held word")
	// an operand read is always followed by the operand load
	`RPN_ASSERT_NEXT(a_rd_then_ld, cmd.rd, cmd.ld, "operand read without load")
	// an operator commit pops exactly one net entry
	`RPN_ASSERT_NEXT(a_commit_pop, cmd.commit, status.level == ($past(status.level) - LVL_W'(1)), "commit did not pop one entry")

endmodule

FILE: verif/rpn_stack_evaluator_tb.sv
// ----------------------------------------------------------------------------
// RPN stack evaluator testbench
// Feeds postfix expressions one character per word and checks every result
// word against an in-bench calculator: directed corner cases first (empty
// stack, sticky errors, overflow, divide by zero, quotient wrap, leftovers,
// receiver backpressure), then random well-formed expressions mixed with noise.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_tb;

	import rpn_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 100;

	typedef struct {
		logic [DATA_W-1:0] value;
		err_t              code;
	} calc_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [CHAR_W-1:0]      s_axis_tdata;   // [7:0] char_code
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [63:0] value, [65:64] error_code, [71:66] zero

	// calculator state mirrored in the bench
	logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
	int unsigned       calc_level;
	err_t              calc_err;
	calc_result_t      awaited_results[$];
	calc_result_t      head_result;

	int unsigned fail_count;
	int unsigned quiet_cycles;
	int unsigned sink_hold_cycles;
	bit          idle_on;

	logic [CHAR_W-1:0] op_chars [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

	rpn_stack_evaluator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Advance the calculator by one accepted character; queue a result on NUL.
	function automatic void evaluate_char(input logic [CHAR_W-1:0] ch);
		logic [DATA_W-1:0] a, b, r, ma, mb, q;
		calc_result_t      res;
		if (ch == CH_NUL) begin
			res.value = '0;
			res.code  = calc_err;
			if (calc_err == ERR_NONE) begin
				if (calc_level == 0)
					res.code = ERR_UNDER;
				else
					res.value = calc_stack[calc_level - 1];
			end
			awaited_results.push_back(res);
			calc_level = 0;
			calc_err   = ERR_NONE;
		end else if (calc_err == ERR_NONE && ch != CH_SPACE) begin
			if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH) begin
				if (calc_level < 2) begin
					calc_err = ERR_UNDER;
				end else begin
					b = calc_stack[calc_level - 1];
					a = calc_stack[calc_level - 2];
					r = '0;
					case (ch)
						CH_PLUS:  r = a + b;
						CH_MINUS: r = a - b;
						CH_STAR:  r = a * b;
						default: begin
							if (b == '0) begin
								calc_err = ERR_DIV0;
							end else begin
								// divide magnitudes, then restore the sign
								ma = a[DATA_W-1] ? -a : a;
								mb = b[DATA_W-1] ? -b : b;
								q  = ma / mb;
								r  = (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
							end
						end
					endcase
					if (calc_err == ERR_NONE) begin
						calc_level = calc_level - 2;
						calc_stack[calc_level] = r;
						calc_level++;
					end
				end
			end else if (calc_level >= STACK_DEPTH) begin
				calc_err = ERR_OVER;
			end else begin
				calc_stack[calc_level] = DATA_W'(ch) - DATA_W'(CH_BIAS);
				calc_level++;
			end
		end
	endfunction

	// Offer one word, with an optional idle burst first; hold valid until taken.
	task automatic send_char(input logic [CHAR_W-1:0] ch);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		evaluate_char(ch);
	endtask

	// Drop valid and wait until every queued result has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	// NUL on an empty stack reports underflow.
	task automatic test_empty_expression();
		send_char(CH_NUL);
		drain_results();
	endtask

	// Every operator, a space, and the extremes of the character code.
	task automatic test_operators_and_extremes();
		send_char(8'd1);        // pushes -47
		send_char(CH_SPACE);
		send_char(8'd255);      // pushes 207
		send_char(CH_STAR);
		send_char(8'd128);      // pushes 80
		send_char(CH_MINUS);
		send_char(8'd127);
		send_char(CH_PLUS);
		send_char(CH_BIAS + 8'd3);
		send_char(CH_SLASH);    // negative quotient, truncated toward zero
		send_char(CH_NUL);
		drain_results();
	endtask

	// Operator with one entry; later characters must be dropped until NUL.
	task automatic test_sticky_underflow();
		send_char(CH_BIAS + 8'd5);
		send_char(CH_PLUS);
		send_char(CH_BIAS + 8'd7);
		send_char(CH_STAR);
		send_char(CH_NUL);
		drain_results();
	endtask

	task automatic test_divide_by_zero();
		send_char(CH_BIAS + 8'd9);
		send_char(CH_BIAS);
		send_char(CH_SLASH);
		send_char(CH_NUL);
		drain_results();
	endtask

	// Fill the stack, push once more, then an operator that must be ignored.
	task automatic test_stack_overflow();
		for (int k = 0; k <= STACK_DEPTH; k++)
			send_char(CH_BIAS + 8'($urandom_range(0, 9)));
		send_char(CH_PLUS);
		send_char(CH_NUL);
		drain_results();
	endtask

	// Build the most negative value as 128^9, divide by -1: wraps, no error.
	task automatic test_quotient_wrap();
		send_char(8'd176);      // pushes 128
		repeat (8) begin
			send_char(8'd176);
			send_char(CH_STAR);
		end
		send_char(CH_BIAS);
		send_char(CH_BIAS + 8'd1);
		send_char(CH_MINUS);
		send_char(CH_SLASH);
		send_char(CH_NUL);
		drain_results();
	endtask

	// Two entries left at NUL: only the top is reported.
	task automatic test_leftover_entries();
		send_char(CH_BIAS + 8'd3);
		send_char(CH_BIAS + 8'd4);
		send_char(CH_NUL);
		drain_results();
	endtask

	// Stall the receiver for a long stretch while expressions keep coming,
	// so the output slot fills and the second NUL backs up the input.
	task automatic test_receiver_stall();
		sink_hold_cycles = 300;
		for (int e = 0; e < 4; e++) begin
			send_char(CH_BIAS + 8'($urandom_range(0, 9)));
			send_char(CH_BIAS + 8'($urandom_range(1, 9)));
			send_char(op_chars[$urandom_range(0, 2)]);
			send_char(CH_NUL);
		end
		drain_results();
	endtask

	// Mostly well-formed expressions with random content, some noise.
	task automatic test_random_expressions(input int unsigned n_words, input bit with_idle);
		int unsigned sent, pushes, goal, depth;
		bit          keep_rest;
		logic [7:0]  ch;
		idle_on = with_idle;
		sent    = 0;
		while (sent < n_words) begin
			if ($urandom_range(0, 6) == 0) begin
				// noise: any code at all, NUL included
				repeat ($urandom_range(1, 10)) begin
					send_char(8'($urandom_range(0, 255)));
					sent++;
				end
			end else begin
				pushes    = 0;
				depth     = 0;
				keep_rest = ($urandom_range(0, 6) == 0);
				goal      = ($urandom_range(0, 9) == 0) ?
					$urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2) : $urandom_range(1, 6);
				// occasionally open with an operator to underflow
				if ($urandom_range(0, 19) == 0) begin
					send_char(op_chars[$urandom_range(0, 3)]);
					sent++;
				end
				while (pushes < goal || (depth > 1 && !keep_rest)) begin
					if ($urandom_range(0, 9) == 0) begin
						send_char(CH_SPACE);
						sent++;
					end
					if (depth >= 2 && (pushes >= goal || $urandom_range(0, 2) == 0)) begin
						send_char(op_chars[$urandom_range(0, 3)]);
						depth--;
					end else begin
						if ($urandom_range(0, 3) != 0)
							ch = CH_BIAS + 8'($urandom_range(0, 9));
						else
							ch = 8'($urandom_range(1, 255));
						send_char(ch);
						depth++;
						pushes++;
					end
					sent++;
				end
				send_char(CH_NUL);
				sent++;
			end
		end
		drain_results();
	endtask

	// Compare each result word with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t unexpected result word: expected none, got %h", $time,
					m_axis_tdata);
				fail_count++;
			end else begin
				head_result = awaited_results.pop_front();
				if (m_axis_tdata[DATA_W-1:0] !== head_result.value) begin
					$display("%0t value mismatch: expected %h, got %h", $time,
						head_result.value, m_axis_tdata[DATA_W-1:0]);
					fail_count++;
				end
				if (m_axis_tdata[DATA_W +: ERR_W] !== head_result.code) begin
					$display("%0t error_code mismatch: expected %0d, got %0d", $time,
						head_result.code, m_axis_tdata[DATA_W +: ERR_W]);
					fail_count++;
				end
				if (m_axis_tdata[OUT_TDATA_W-1:DATA_W+ERR_W] !== '0) begin
					$display("%0t padding mismatch: expected 0, got %h", $time,
						m_axis_tdata[OUT_TDATA_W-1:DATA_W+ERR_W]);
					fail_count++;
				end
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold when a test asks for one.
	initial begin
		int unsigned hold;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold_cycles != 0) begin
				hold             = sink_hold_cycles;
				sink_hold_cycles = 0;
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Abort when neither side has moved a word for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n           = 1'b0;
		s_axis_tvalid    = 1'b0;
		s_axis_tdata     = '0;
		fail_count       = 0;
		quiet_cycles     = 0;
		sink_hold_cycles = 0;
		idle_on          = 1'b1;
		calc_level       = 0;
		calc_err         = ERR_NONE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_expression();
		test_operators_and_extremes();
		test_sticky_underflow();
		test_divide_by_zero();
		test_stack_overflow();
		test_quotient_wrap();
		test_leftover_entries();
		test_receiver_stall();
		test_random_expressions(650, 1'b1);
		test_random_expressions(230, 1'b0);

		// settle: anything arriving now has no expectation and is flagged
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaited_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
